[rtl/core/ctc_pkg.sv]
// Shared types, keyword table and code constants for the command token classifier.
package ctc_pkg;

   // Fixed field widths of the result beat.
   localparam int unsigned FIELD_W   = 12;
   localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

   // Byte codes that steer the lexer.
   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] SLASH_BYTE = 8'h2F;
   localparam logic [7:0] DOT_BYTE   = 8'h2E;
   localparam logic [7:0] ZERO_BYTE  = 8'h30;
   localparam logic [7:0] NINE_BYTE  = 8'h39;

   // Largest octet value and the saturation value of a part.
   localparam logic [8:0] OCTET_MAX = 9'd255;
   localparam logic [8:0] PART_SAT  = 9'd256;
   localparam logic [2:0] DOTS_QUAD = 3'd3;
   localparam logic [2:0] DOTS_SAT  = 3'd5;

   // Keyword table: text stored left aligned, padded with zero bytes.
   localparam int unsigned KW_NUM   = 8;
   localparam int unsigned KW_CHARS = 17;

   localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_NUM] = '{
      {"show",              {13{8'h00}}},
      {"ip",                {15{8'h00}}},
      {"bgp",               {14{8'h00}}},
      {"summary",           {10{8'h00}}},
      {"neighbors",         {8{8'h00}}},
      {"neighbours",        {7{8'h00}}},
      {"advertised-routes"},
      {"received-routes",   {2{8'h00}}}
   };

   localparam logic [4:0] KW_LEN [KW_NUM] = '{
      5'd4, 5'd2, 5'd3, 5'd7, 5'd9, 5'd10, 5'd17, 5'd15
   };

   // Token classes reported on the result channel.
   typedef enum logic [2:0] {
      KIND_KEYWORD    = 3'd0,
      KIND_ADDRESS    = 3'd1,
      KIND_ADDR_SLASH = 3'd2,
      KIND_OTHER      = 3'd3,
      KIND_LINE_EMPTY = 3'd4
   } token_kind_type;

   // Per-token lexer state.
   typedef struct packed {
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] length;
      logic [KW_NUM-1:0]  kw_alive;
      logic               slash_seen;
      logic               address_bad;
      logic [2:0]         dot_count;
      logic [8:0]         part_value;
      logic               part_has_digit;
   } tok_state_type;

   localparam tok_state_type TOK_CLEAR = '{
      start:          '0,
      length:         '0,
      kw_alive:       '1,
      slash_seen:     1'b0,
      address_bad:    1'b0,
      dot_count:      '0,
      part_value:     '0,
      part_has_digit: 1'b0
   };

   // One result beat.
   typedef struct packed {
      token_kind_type     kind;
      logic               accepted;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] length;
      logic               line_last;
   } result_type;

   // Character of keyword k at offset idx; zero past the keyword's end.
   function automatic logic [7:0] kw_char(input int unsigned k, input logic [4:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (idx < KW_LEN[k]) begin
         ch = KW_TEXT[k][(KW_CHARS - 1 - idx) * 8 +: 8];
      end
      return ch;
   endfunction

endpackage

[rtl/core/ctc_token_step.sv]
// Combinational lexer step: updates token state for one byte and forms the result.
module ctc_token_step (
   input  ctc_pkg::tok_state_type       state_i,
   input  logic [ctc_pkg::FIELD_W-1:0]  position,
   input  logic [7:0]                   char_byte,
   input  logic                         line_end,
   output ctc_pkg::tok_state_type       state_o,
   output logic                         produce,
   output ctc_pkg::result_type          result
);
   import ctc_pkg::*;

   tok_state_type taken;
   logic [11:0]   digit_sum;
   logic          is_space;
   logic          is_digit;
   logic          kw_hit;
   logic          addr_ok;

   assign is_space = (char_byte == SPACE_BYTE);
   assign is_digit = (char_byte >= ZERO_BYTE) && (char_byte <= NINE_BYTE);

   // Decimal accumulate of the current part; an ASCII digit's low nibble is its value.
   assign digit_sum = ({3'b000, state_i.part_value} * 12'd10) + {8'h00, char_byte[3:0]};

   // Fold a non-space byte into the token.
   always_comb begin
      taken = state_i;
      if (!is_space) begin
         if (state_i.length == '0) begin
            taken.start = position;
         end
         // Drop every keyword whose text differs at this offset.
         for (int k = 0; k < KW_NUM; k++) begin
            if ((state_i.length >= {7'b0, KW_LEN[k]}) ||
                (kw_char(k, state_i.length[4:0]) != char_byte)) begin
               taken.kw_alive[k] = 1'b0;
            end
         end
         // Dotted quad tracking up to the first slash.
         if (!state_i.slash_seen) begin
            if (char_byte == SLASH_BYTE) begin
               taken.slash_seen = 1'b1;
            end else if (char_byte == DOT_BYTE) begin
               if (!state_i.part_has_digit || state_i.part_value[8]) begin
                  taken.address_bad = 1'b1;
               end
               if (state_i.dot_count < DOTS_SAT) begin
                  taken.dot_count = state_i.dot_count + 3'd1;
               end
               taken.part_value     = '0;
               taken.part_has_digit = 1'b0;
            end else if (is_digit) begin
               taken.part_value = (digit_sum > {3'b000, PART_SAT}) ? PART_SAT
                                                                 : digit_sum[8:0];
               taken.part_has_digit = 1'b1;
            end else begin
               taken.address_bad = 1'b1;
            end
         end
         if (state_i.length != FIELD_MAX) begin
            taken.length = state_i.length + FIELD_W'(1);
         end
      end
   end

   // Classify the token as it stands after this byte.
   always_comb begin
      kw_hit = 1'b0;
      for (int k = 0; k < KW_NUM; k++) begin
         if (taken.kw_alive[k] && (taken.length == {7'b0, KW_LEN[k]})) begin
            kw_hit = 1'b1;
         end
      end
   end

   assign addr_ok = !taken.address_bad && taken.part_has_digit &&
                    (taken.part_value <= OCTET_MAX) && (taken.dot_count == DOTS_QUAD);

   // Result selection and the state left for the next byte.
   always_comb begin
      produce          = 1'b0;
      result.kind      = KIND_OTHER;
      result.accepted  = 1'b0;
      result.start     = taken.start;
      result.length    = taken.length;
      result.line_last = line_end;
      state_o          = taken;
      if ((taken.length != '0) && (is_space || line_end)) begin
         produce = 1'b1;
         if (kw_hit) begin
            result.kind = KIND_KEYWORD;
         end else if (addr_ok) begin
            result.kind = taken.slash_seen ? KIND_ADDR_SLASH : KIND_ADDRESS;
         end else begin
            result.kind = KIND_OTHER;
         end
         result.accepted = (result.kind != KIND_OTHER);
         state_o         = TOK_CLEAR;
      end else if (line_end) begin
         produce         = 1'b1;
         result.kind     = KIND_LINE_EMPTY;
         result.accepted = 1'b0;
         result.start    = '0;
         result.length   = '0;
         state_o         = TOK_CLEAR;
      end
   end

endmodule

[rtl/core/command_token_classifier.sv]
// Top level of the command token classifier: input register, lexer step, result register.
// The block takes one byte of a command line per beat and gives at most one result beat
// per input beat: a token's class when a space or the line's last byte ends it, or a
// line-end marker when the line ends on a space with no token open. A new byte can be
// taken every cycle while no result beat is stalled; an accepted byte goes through the
// input register, a single lexer step and the result register to its result beat. An
// input byte waits in the input register only while the result register holds a beat
// that is stalled. Byte offsets saturate at MAX_LINE_BYTES - 1 (at most 4095).
module command_token_classifier #(
   parameter int unsigned MAX_LINE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_line_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic        rsp_accepted,
   output logic [11:0] rsp_token_start,
   output logic [11:0] rsp_token_length,
   output logic        rsp_line_last
);
   import ctc_pkg::*;

   localparam int unsigned POS_MAX_INT =
      ((MAX_LINE_BYTES - 1) < 4095) ? (MAX_LINE_BYTES - 1) : 4095;
   localparam logic [FIELD_W-1:0] POS_MAX = FIELD_W'(POS_MAX_INT);

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   logic [FIELD_W-1:0] position_ff;
   logic [FIELD_W-1:0] position_in;
   tok_state_type      tok_ff;
   tok_state_type      tok_in;
   logic               produce;
   result_type         result;
   logic               advance;
   logic               rsp_valid_ff;
   result_type         rsp_ff;

   // The held byte moves on whenever the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_char_byte;
         in_last_ff <= req_line_end;
      end
   end

   // Lexer step for the held byte.
   ctc_token_step u_step (
      .state_i   (tok_ff),
      .position  (position_ff),
      .char_byte (in_byte_ff),
      .line_end  (in_last_ff),
      .state_o   (tok_in),
      .produce   (produce),
      .result    (result)
   );

   // Byte offset in the line, saturating and cleared by the last byte.
   always_comb begin
      position_in = position_ff;
      if (in_last_ff) begin
         position_in = '0;
      end else if (position_ff < POS_MAX) begin
         position_in = position_ff + FIELD_W'(1);
      end
   end

   // Token and line state.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         tok_ff      <= TOK_CLEAR;
      end else if (advance) begin
         position_ff <= position_in;
         tok_ff      <= tok_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= advance && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_kind   = rsp_ff.kind;
   assign rsp_accepted     = rsp_ff.accepted;
   assign rsp_token_start  = rsp_ff.start;
   assign rsp_token_length = rsp_ff.length;
   assign rsp_line_last    = rsp_ff.line_last;

endmodule
